// ----- hw/rtl/pcms_pkg.sv -----
`default_nettype none
package pcms_pkg;

  localparam int MAX_COLUMNS_DEF = 16;
  localparam int MAX_LINES_DEF   = 256;

  localparam int SAMPLE_W     = 24;
  localparam int SUM_W        = 34;
  localparam int SQ_W         = 57;
  localparam int MAGSQ_W      = 48;
  localparam int N_W          = 10;
  localparam int COLS_CFG_W   = 5;
  localparam int LINES_CFG_W  = 9;
  localparam int CFG_DATA_W   = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int WORD_W       = SUM_W + SQ_W;
  localparam int PROD_W       = 68;
  localparam int MPLIER_W     = 34;
  localparam int DVS_W        = 20;
  localparam int VAR_W        = 64;
  localparam int ROOT_W       = 32;
  localparam int RREM_W       = 34;
  localparam int CNT_W        = 7;

  localparam int MUL_N_STEPS  = 10;
  localparam int MUL_S_STEPS  = 34;
  localparam int DIV_STEPS    = 68;
  localparam int ROOT_STEPS   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 2'd2;

  localparam logic [N_W-1:0]         SAMPLE_COUNT_RST = 10'd2;
  localparam logic [COLS_CFG_W-1:0]  COLUMN_COUNT_RST = 5'd1;
  localparam logic [LINES_CFG_W-1:0] LINE_COUNT_RST   = 9'd1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_LOAD,
    ST_MUL_SQ,
    ST_SETUP_SS,
    ST_MUL_SS,
    ST_SETUP_DEN,
    ST_MUL_DEN,
    ST_SETUP_VAR,
    ST_DIV_VAR,
    ST_SETUP_MEAN,
    ST_DIV_MEAN,
    ST_SETUP_COL,
    ST_DIV_COL,
    ST_SETUP_ROOT,
    ST_ROOT,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_ACC_WRITE,
    OP_LOAD,
    OP_MUL_STEP,
    OP_SETUP_SS,
    OP_SETUP_DEN,
    OP_SETUP_VAR,
    OP_DIV_STEP,
    OP_SETUP_MEAN,
    OP_SETUP_COL,
    OP_SETUP_ROOT,
    OP_ROOT_STEP,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   read_cell;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pcms_if.sv -----
`default_nettype none
interface pcms_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic signed [pcms_pkg::SAMPLE_W-1:0]  sample_value;
  modport source (output valid, output command, output sample_value, input ready);
  modport sink (input valid, input command, input sample_value, output ready);
endinterface

interface pcms_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [pcms_pkg::SAMPLE_W-1:0] mean_value;
  logic [pcms_pkg::SAMPLE_W-1:0]  std_deviation;
  logic                           end_of_line;
  logic                           last_cell;
  modport source (output valid, output mean_value, output std_deviation,
                  output end_of_line, output last_cell, input ready);
  modport sink (input valid, input mean_value, input std_deviation,
                input end_of_line, input last_cell, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pcms_ram.sv -----
`default_nettype none
module pcms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/pcms_ctrl.sv -----
`default_nettype none
module pcms_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_cmd,
  output logic                       in_ready,
  input  wire pcms_pkg::dp_status_t  status,
  output pcms_pkg::dp_cmd_t          cmd
);
  pcms_pkg::state_t                 state_r, state_nxt;
  logic [pcms_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcms_pkg::ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_ready      = 1'b0;
    cmd.op        = pcms_pkg::OP_NONE;
    cmd.read_cell = 1'b0;
    unique case (state_r)
      pcms_pkg::ST_CLEAR: begin
        cmd.op = pcms_pkg::OP_CLEAR;
        if (status.clr_last) state_nxt = pcms_pkg::ST_IDLE;
      end
      pcms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op        = pcms_pkg::OP_ACCEPT;
          cmd.read_cell = in_cmd;
          state_nxt     = in_cmd ? pcms_pkg::ST_LOAD : pcms_pkg::ST_ACC;
        end
      end
      pcms_pkg::ST_ACC: begin
        cmd.op    = pcms_pkg::OP_ACC_WRITE;
        state_nxt = pcms_pkg::ST_IDLE;
      end
      pcms_pkg::ST_LOAD: begin
        cmd.op    = pcms_pkg::OP_LOAD;
        cnt_nxt   = pcms_pkg::CNT_W'(pcms_pkg::MUL_N_STEPS - 1);
        state_nxt = pcms_pkg::ST_MUL_SQ;
      end
      pcms_pkg::ST_MUL_SQ: begin
        cmd.op = pcms_pkg::OP_MUL_STEP;
        if (cnt_r == '0) state_nxt = pcms_pkg::ST_SETUP_SS;
        else cnt_nxt = cnt_r - 1'b1;
      end
      pcms_pkg::ST_SETUP_SS: begin
        cmd.op    = pcms_pkg::OP_SETUP_SS;
        cnt_nxt   = pcms_pkg::CNT_W'(pcms_pkg::MUL_S_STEPS - 1);
        state_nxt = pcms_pkg::ST_MUL_SS;
      end
      pcms_pkg::ST_MUL_SS: begin
        cmd.op = pcms_pkg::OP_MUL_STEP;
        if (cnt_r == '0) state_nxt = pcms_pkg::ST_SETUP_DEN;
        else cnt_nxt = cnt_r - 1'b1;
      end
      pcms_pkg::ST_SETUP_DEN: begin
        cmd.op    = pcms_pkg::OP_SETUP_DEN;
        cnt_nxt   = pcms_pkg::CNT_W'(pcms_pkg::MUL_N_STEPS - 1);
        state_nxt = pcms_pkg::ST_MUL_DEN;
      end
      pcms_pkg::ST_MUL_DEN: begin
        cmd.op = pcms_pkg::OP_MUL_STEP;
        if (cnt_r == '0) state_nxt = pcms_pkg::ST_SETUP_VAR;
        else cnt_nxt = cnt_r - 1'b1;
      end
      pcms_pkg::ST_SETUP_VAR: begin
        cmd.op    = pcms_pkg::OP_SETUP_VAR;
        cnt_nxt   = pcms_pkg::CNT_W'(pcms_pkg::DIV_STEPS - 1);
        state_nxt = pcms_pkg::ST_DIV_VAR;
      end
      pcms_pkg::ST_DIV_VAR: begin
        cmd.op = pcms_pkg::OP_DIV_STEP;
        if (cnt_r == '0) state_nxt = pcms_pkg::ST_SETUP_MEAN;
        else cnt_nxt = cnt_r - 1'b1;
      end
      pcms_pkg::ST_SETUP_MEAN: begin
        cmd.op    = pcms_pkg::OP_SETUP_MEAN;
        cnt_nxt   = pcms_pkg::CNT_W'(pcms_pkg::DIV_STEPS - 1);
        state_nxt = pcms_pkg::ST_DIV_MEAN;
      end
      pcms_pkg::ST_DIV_MEAN: begin
        cmd.op = pcms_pkg::OP_DIV_STEP;
        if (cnt_r == '0) state_nxt = pcms_pkg::ST_SETUP_COL;
        else cnt_nxt = cnt_r - 1'b1;
      end
      pcms_pkg::ST_SETUP_COL: begin
        cmd.op    = pcms_pkg::OP_SETUP_COL;
        cnt_nxt   = pcms_pkg::CNT_W'(pcms_pkg::DIV_STEPS - 1);
        state_nxt = pcms_pkg::ST_DIV_COL;
      end
      pcms_pkg::ST_DIV_COL: begin
        cmd.op = pcms_pkg::OP_DIV_STEP;
        if (cnt_r == '0) state_nxt = pcms_pkg::ST_SETUP_ROOT;
        else cnt_nxt = cnt_r - 1'b1;
      end
      pcms_pkg::ST_SETUP_ROOT: begin
        cmd.op    = pcms_pkg::OP_SETUP_ROOT;
        cnt_nxt   = pcms_pkg::CNT_W'(pcms_pkg::ROOT_STEPS - 1);
        state_nxt = pcms_pkg::ST_ROOT;
      end
      pcms_pkg::ST_ROOT: begin
        cmd.op = pcms_pkg::OP_ROOT_STEP;
        if (cnt_r == '0) state_nxt = pcms_pkg::ST_FINISH;
        else cnt_nxt = cnt_r - 1'b1;
      end
      pcms_pkg::ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.op    = pcms_pkg::OP_FINISH;
          state_nxt = pcms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pcms_pkg::ST_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/pcms_dp.sv -----
`default_nettype none
module pcms_dp #(
  parameter int MAX_COLUMNS = pcms_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_LINES   = pcms_pkg::MAX_LINES_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire pcms_pkg::dp_cmd_t                      cmd,
  output pcms_pkg::dp_status_t                        status,
  input  wire logic signed [pcms_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic                                   cfg_we,
  input  wire logic [pcms_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [pcms_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [pcms_pkg::SAMPLE_W-1:0]        out_mean,
  output logic [pcms_pkg::SAMPLE_W-1:0]               out_sd,
  output logic                                        out_eol,
  output logic                                        out_last
);
  localparam int DEPTH = MAX_COLUMNS * MAX_LINES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int LW    = $clog2(MAX_LINES + 1);
  localparam int SW    = pcms_pkg::SAMPLE_W;
  localparam int PW    = pcms_pkg::PROD_W;
  localparam int DW    = pcms_pkg::DVS_W;

  logic [pcms_pkg::N_W-1:0]         n_r;
  logic [pcms_pkg::COLS_CFG_W-1:0]  col_r;
  logic [pcms_pkg::LINES_CFG_W-1:0] line_r;
  logic [AW-1:0]                    fill_ptr_r, rd_ptr_r, cell_r, clr_addr_r;
  logic [SW-1:0]                    samp_r;
  logic [pcms_pkg::MAGSQ_W-1:0]     magsq_r;
  logic [pcms_pkg::SUM_W-1:0]       smag_r;
  logic                             neg_r;
  logic [PW-1:0]                    mcand_r, prod_r, p_r, q_r, dvd_r;
  logic [pcms_pkg::MPLIER_W-1:0]    mplier_r;
  logic [DW-1:0]                    rem_r, dvs_r;
  logic                             var_ok_r;
  logic [pcms_pkg::VAR_W-1:0]       var_r, v_r;
  logic [pcms_pkg::RREM_W-1:0]      rrem_r;
  logic [pcms_pkg::ROOT_W-1:0]      root_r;
  logic [SW-1:0]                    mean_r;
  logic                             eol_r, last_r;

  logic [CW-1:0]                    cols_c;
  logic [LW-1:0]                    lines_c;
  logic [AW:0]                      cells_c;
  logic [pcms_pkg::N_W-1:0]         n_c;
  logic [AW-1:0]                    fp_c, rp_c, adv_c;
  logic [pcms_pkg::WORD_W-1:0]      rdata, wdata;
  logic [AW-1:0]                    waddr, raddr;
  logic                             we;
  logic [pcms_pkg::SUM_W-1:0]       rd_sum, rd_smag;
  logic [pcms_pkg::SQ_W-1:0]        rd_sq;
  logic [SW-1:0]                    in_mag;
  logic [DW:0]                      div_t;
  logic                             div_ge;
  logic [pcms_pkg::RREM_W-1:0]      rt_t, rt_trial;
  logic                             rt_ge;
  logic [pcms_pkg::ROOT_W:0]        sd_c;
  logic [SW-1:0]                    mean_c;
  logic [pcms_pkg::SUM_W:0]         mean_dvd;

  always_comb begin
    if (col_r == '0) cols_c = CW'(1);
    else if (32'(col_r) > MAX_COLUMNS) cols_c = CW'(MAX_COLUMNS);
    else cols_c = CW'(col_r);
    if (line_r == '0) lines_c = LW'(1);
    else if (32'(line_r) > MAX_LINES) lines_c = LW'(MAX_LINES);
    else lines_c = LW'(line_r);
    cells_c = (AW+1)'((AW+1)'(cols_c) * (AW+1)'(lines_c));
    n_c     = (n_r < pcms_pkg::N_W'(2)) ? pcms_pkg::N_W'(2) : n_r;
    fp_c    = ({1'b0, fill_ptr_r} >= cells_c) ? '0 : fill_ptr_r;
    rp_c    = ({1'b0, rd_ptr_r} >= cells_c) ? '0 : rd_ptr_r;
    adv_c   = ({1'b0, cell_r} + (AW+1)'(1) >= cells_c) ? '0 : cell_r + 1'b1;
  end

  assign rd_sum  = rdata[pcms_pkg::SUM_W-1:0];
  assign rd_sq   = rdata[pcms_pkg::WORD_W-1:pcms_pkg::SUM_W];
  assign rd_smag = rd_sum[pcms_pkg::SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;
  assign in_mag  = in_sample[SW-1] ? (~in_sample + 1'b1) : in_sample;

  assign div_t    = {rem_r, dvd_r[PW-1]};
  assign div_ge   = div_t >= {1'b0, dvs_r};
  assign rt_t     = {rrem_r[pcms_pkg::RREM_W-3:0], v_r[pcms_pkg::VAR_W-1 -: 2]};
  assign rt_trial = {root_r, 2'b01};
  assign rt_ge    = rt_t >= rt_trial;
  assign sd_c     = (rrem_r > pcms_pkg::RREM_W'(root_r)) ? {1'b0, root_r} + 1'b1
                                                          : {1'b0, root_r};
  assign mean_dvd = {1'b0, smag_r} + (pcms_pkg::SUM_W+1)'(n_c >> 1);

  always_comb begin
    if (neg_r) begin
      if (dvd_r > PW'(24'h800000)) mean_c = 24'h800000;
      else mean_c = ~dvd_r[SW-1:0] + 1'b1;
    end else begin
      if (dvd_r > PW'(24'h7FFFFF)) mean_c = 24'h7FFFFF;
      else mean_c = dvd_r[SW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cell_r;
    wdata = '0;
    raddr = cmd.read_cell ? rp_c : fp_c;
    case (cmd.op)
      pcms_pkg::OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr_r;
      end
      pcms_pkg::OP_ACC_WRITE: begin
        we    = 1'b1;
        wdata = {rd_sq + pcms_pkg::SQ_W'(magsq_r),
                 rd_sum + {{(pcms_pkg::SUM_W-SW){samp_r[SW-1]}}, samp_r}};
      end
      pcms_pkg::OP_FINISH: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  pcms_ram #(
    .WIDTH (pcms_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r        <= pcms_pkg::SAMPLE_COUNT_RST;
      col_r      <= pcms_pkg::COLUMN_COUNT_RST;
      line_r     <= pcms_pkg::LINE_COUNT_RST;
      fill_ptr_r <= '0;
      rd_ptr_r   <= '0;
      clr_addr_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pcms_pkg::CFG_SAMPLE_COUNT: n_r <= cfg_data;
          pcms_pkg::CFG_COLUMN_COUNT: col_r <= cfg_data[pcms_pkg::COLS_CFG_W-1:0];
          pcms_pkg::CFG_LINE_COUNT:   line_r <= cfg_data[pcms_pkg::LINES_CFG_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == pcms_pkg::OP_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.op == pcms_pkg::OP_ACC_WRITE) fill_ptr_r <= adv_c;
      if (cmd.op == pcms_pkg::OP_FINISH) begin
        rd_ptr_r  <= adv_c;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      pcms_pkg::OP_ACCEPT: begin
        cell_r  <= raddr;
        samp_r  <= in_sample;
        magsq_r <= pcms_pkg::MAGSQ_W'(in_mag) * pcms_pkg::MAGSQ_W'(in_mag);
      end
      pcms_pkg::OP_LOAD: begin
        neg_r    <= rd_sum[pcms_pkg::SUM_W-1];
        smag_r   <= rd_smag;
        mcand_r  <= PW'(rd_sq);
        mplier_r <= pcms_pkg::MPLIER_W'(n_c);
        prod_r   <= '0;
      end
      pcms_pkg::OP_MUL_STEP: begin
        if (mplier_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
      end
      pcms_pkg::OP_SETUP_SS: begin
        p_r      <= prod_r;
        mcand_r  <= PW'(smag_r);
        mplier_r <= smag_r;
        prod_r   <= '0;
      end
      pcms_pkg::OP_SETUP_DEN: begin
        q_r      <= prod_r;
        mcand_r  <= PW'(n_c);
        mplier_r <= pcms_pkg::MPLIER_W'(n_c - 1'b1);
        prod_r   <= '0;
      end
      pcms_pkg::OP_SETUP_VAR: begin
        var_ok_r <= p_r >= q_r;
        dvd_r    <= p_r - q_r;
        dvs_r    <= prod_r[DW-1:0];
        rem_r    <= '0;
      end
      pcms_pkg::OP_DIV_STEP: begin
        rem_r <= div_ge ? DW'(div_t - {1'b0, dvs_r}) : div_t[DW-1:0];
        dvd_r <= {dvd_r[PW-2:0], div_ge};
      end
      pcms_pkg::OP_SETUP_MEAN: begin
        if (!var_ok_r) var_r <= '0;
        else if (|dvd_r[PW-1:pcms_pkg::VAR_W]) var_r <= '1;
        else var_r <= dvd_r[pcms_pkg::VAR_W-1:0];
        dvd_r <= PW'(mean_dvd);
        dvs_r <= DW'(n_c);
        rem_r <= '0;
      end
      pcms_pkg::OP_SETUP_COL: begin
        mean_r <= mean_c;
        dvd_r  <= PW'(cell_r);
        dvs_r  <= DW'(cols_c);
        rem_r  <= '0;
      end
      pcms_pkg::OP_SETUP_ROOT: begin
        eol_r  <= rem_r == DW'(cols_c - 1'b1);
        last_r <= {1'b0, cell_r} == cells_c - 1'b1;
        v_r    <= var_r;
        rrem_r <= '0;
        root_r <= '0;
      end
      pcms_pkg::OP_ROOT_STEP: begin
        rrem_r <= rt_ge ? rt_t - rt_trial : rt_t;
        root_r <= {root_r[pcms_pkg::ROOT_W-2:0], rt_ge};
        v_r    <= v_r << 2;
      end
      pcms_pkg::OP_FINISH: begin
        out_mean <= mean_r;
        out_sd   <= (|sd_c[pcms_pkg::ROOT_W:SW]) ? '1 : sd_c[SW-1:0];
        out_eol  <= eol_r;
        out_last <= last_r;
      end
      default: ;
    endcase
  end

  assign status.clr_last = clr_addr_r == AW'(DEPTH - 1);
  assign status.out_busy = out_valid & ~out_ready;
endmodule
`default_nettype wire

// ----- hw/rtl/per_cell_mean_stddev.sv -----
// Accumulate beat: the cell is updated in ST_ACC before the next beat can be taken.
// Read-out beat: from acceptance to the result register the beat passes the serial
//   shift-add multiplier (10+34+10), three 68-step restoring divisions and a 32-step
//   square root, all on one shared datapath; the next beat is taken after the result
//   is written, which waits while the previous result is still stalled.
// Reset: synchronous, active low; a clearing pass then zeroes the cell store, all
//   MAX_COLUMNS*MAX_LINES entries (4096 by default), one entry per cycle, input held off.
`default_nettype none
module per_cell_mean_stddev #(
  parameter int MAX_COLUMNS = pcms_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_LINES   = pcms_pkg::MAX_LINES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  pcms_in_if.sink                                 in_bus,
  pcms_out_if.source                              out_bus,
  input  wire logic                               cfg_we,
  input  wire logic [pcms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pcms_pkg::CFG_DATA_W-1:0]    cfg_data
);
  pcms_pkg::dp_cmd_t    cmd;
  pcms_pkg::dp_status_t status;

  pcms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_cmd   (in_bus.command),
    .in_ready (in_bus.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pcms_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_LINES   (MAX_LINES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_sample (in_bus.sample_value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_mean  (out_bus.mean_value),
    .out_sd    (out_bus.std_deviation),
    .out_eol   (out_bus.end_of_line),
    .out_last  (out_bus.last_cell)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/pcms_checker.sv -----
`default_nettype none
module pcms_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [pcms_pkg::SAMPLE_W-1:0] out_mean,
  input wire logic [pcms_pkg::SAMPLE_W-1:0] out_sd,
  input wire logic                          out_eol,
  input wire logic                          out_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_sd))
    else $error("result beat changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during store clearing");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in work");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_eol)
    else $error("last cell not flagged as end of line");
endmodule

bind per_cell_mean_stddev pcms_checker u_pcms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_mean  (out_bus.mean_value),
  .out_sd    (out_bus.std_deviation),
  .out_eol   (out_bus.end_of_line),
  .out_last  (out_bus.last_cell)
);
`default_nettype wire
